>>> rtl/dtt_pkg.sv
// ----------------------------------------------------------------------------
// dtt_pkg: shared types and constants of the delayed action timer table
// Entry layout, cell control bundle, command and status codes, FSM states.
// ----------------------------------------------------------------------------
`default_nettype none
package dtt_pkg;

  localparam int unsigned TABLE_DEPTH = 32;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0]  PHASE_EMPTY = 2'd0;
  localparam logic [1:0]  PHASE_AFTER = 2'd2;
  localparam logic [15:0] TIME_DAEMON = 16'hFFFF;
  localparam logic [15:0] TIME_ONE    = 16'd1;

  typedef enum logic [2:0] {
    OP_INSERT   = 3'd0,
    OP_LENGTHEN = 3'd1,
    OP_EXTING   = 3'd2,
    OP_FIND     = 3'd3,
    OP_DAEMONS  = 3'd4,
    OP_TICK     = 3'd5
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PRE,
    S_WALK,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] arg;
    logic [1:0]  phase;
    logic [15:0] tim;
  } entry_t;

  // Cells below lim take their right neighbor; cell wr_idx takes wr_data.
  typedef struct packed {
    logic             shift_en;
    logic [CNT_W-1:0] lim;
    logic             wr_en;
    logic [CNT_W-1:0] wr_idx;
    entry_t           wr_data;
  } cell_ctrl_t;

endpackage
`default_nettype wire

>>> rtl/dtt_cell.sv
// ----------------------------------------------------------------------------
// dtt_cell: one table slot
// Holds one entry; shifts in its right neighbor or takes a direct write.
// ----------------------------------------------------------------------------
`default_nettype none
module dtt_cell (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic [dtt_pkg::CNT_W-1:0] idx_i,
  input  wire dtt_pkg::cell_ctrl_t      ctrl_i,
  input  wire dtt_pkg::entry_t          right_i,
  output dtt_pkg::entry_t               entry_o
);

  dtt_pkg::entry_t entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.shift_en && (idx_i < ctrl_i.lim)) begin
      entry_d = right_i;
    end else if (ctrl_i.wr_en && (idx_i == ctrl_i.wr_idx)) begin
      entry_d = ctrl_i.wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule
`default_nettype wire

>>> rtl/dtt_chain.sv
// ----------------------------------------------------------------------------
// dtt_chain: row of table cells
// Slot 0 is the head that the controller examines on every walk step.
// ----------------------------------------------------------------------------
`default_nettype none
module dtt_chain (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire dtt_pkg::cell_ctrl_t ctrl_i,
  output dtt_pkg::entry_t          head_o
);

  dtt_pkg::entry_t cells [dtt_pkg::TABLE_DEPTH];

  for (genvar k = 0; k < dtt_pkg::TABLE_DEPTH; k++) begin : g_cell
    dtt_pkg::entry_t right;
    if (k == dtt_pkg::TABLE_DEPTH - 1) begin : g_end
      assign right = '0;
    end else begin : g_mid
      assign right = cells[k+1];
    end
    dtt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (dtt_pkg::CNT_W'(k)),
      .ctrl_i  (ctrl_i),
      .right_i (right),
      .entry_o (cells[k])
    );
  end

  assign head_o = cells[0];

endmodule
`default_nettype wire

>>> rtl/delayed_action_timer_table_unit.sv
// ----------------------------------------------------------------------------
// delayed_action_timer_table_unit: compacted table of delayed actions
// Command port in, strobed result stream out, table kept in a cell chain.
// ----------------------------------------------------------------------------
//  channel   | handshake       | payload
//  ----------+-----------------+------------------------------------------------
//  command   | start, busy     | opcode, action_id, action_arg, phase, amount
//  result    | valid_o strobe  | fired, fired_id, fired_arg, status, slot,
//            |                 | entry_count, last
//
// Insert and unknown commands go straight to the closing result; the others
// walk the table, tick after one unchanged rotation. The walk pops one entry
// per cycle off the head of the cell chain and puts it back unless dropped.
// Reset clears the whole table at once. Results are strobed for one cycle each;
// busy stays high until the closing result is issued.
`default_nettype none
module delayed_action_timer_table_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  opcode_i,
  input  wire logic [7:0]  action_id_i,
  input  wire logic [15:0] action_arg_i,
  input  wire logic [1:0]  phase_i,
  input  wire logic signed [15:0] amount_i,
  output logic             valid_o,
  output logic             fired_o,
  output logic [7:0]       fired_id_o,
  output logic [15:0]      fired_arg_o,
  output logic [1:0]       status_o,
  output logic [4:0]       slot_o,
  output logic [5:0]       entry_count_o,
  output logic             last_o
);

  localparam int unsigned CW = dtt_pkg::CNT_W;
  localparam int unsigned IW = dtt_pkg::IDX_W;

  dtt_pkg::state_e     state_q, state_d;
  dtt_pkg::cell_ctrl_t ctrl;
  dtt_pkg::entry_t     head, tail;

  logic [2:0]    op_q, op_d;
  logic [7:0]    id_q, id_d;
  logic [15:0]   arg_q, arg_d;
  logic [1:0]    ph_q, ph_d;
  logic [15:0]   amt_q, amt_d;
  logic [CW-1:0] used_q, used_d;
  logic [CW-1:0] rem_q, rem_d;
  logic [CW-1:0] len_q, len_d;
  logic [CW-1:0] kept_q, kept_d;
  logic [CW-1:0] fin_q, fin_d;
  logic          hit_q, hit_d;
  logic [1:0]    rstat_q, rstat_d;
  logic [IW-1:0] rslot_q, rslot_d;

  logic          ov_q, ov_d, of_q, of_d, ol_q, ol_d;
  logic [7:0]    oid_q, oid_d;
  logic [15:0]   oarg_q, oarg_d;
  logic [1:0]    ost_q, ost_d;
  logic [IW-1:0] oslot_q, oslot_d;
  logic [CW-1:0] ocnt_q, ocnt_d;

  logic          drop, fire, match;
  logic [15:0]   tdec;

  dtt_chain u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .head_o (head)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dtt_pkg::S_IDLE;
      used_q  <= '0;
      rem_q   <= '0;
      len_q   <= '0;
      kept_q  <= '0;
      fin_q   <= '0;
      hit_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      rem_q   <= rem_d;
      len_q   <= len_d;
      kept_q  <= kept_d;
      fin_q   <= fin_d;
      hit_q   <= hit_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    id_q    <= id_d;
    arg_q   <= arg_d;
    ph_q    <= ph_d;
    amt_q   <= amt_d;
    rstat_q <= rstat_d;
    rslot_q <= rslot_d;
    of_q    <= of_d;
    ol_q    <= ol_d;
    oid_q   <= oid_d;
    oarg_q  <= oarg_d;
    ost_q   <= ost_d;
    oslot_q <= oslot_d;
    ocnt_q  <= ocnt_d;
  end

  always_comb begin
    state_d = state_q;
    op_d = op_q; id_d = id_q; arg_d = arg_q; ph_d = ph_q; amt_d = amt_q;
    used_d = used_q; rem_d = rem_q; len_d = len_q; kept_d = kept_q;
    fin_d = fin_q; hit_d = hit_q; rstat_d = rstat_q; rslot_d = rslot_q;
    ov_d = 1'b0; of_d = of_q; ol_d = ol_q; oid_d = oid_q; oarg_d = oarg_q;
    ost_d = ost_q; oslot_d = oslot_q; ocnt_d = ocnt_q;
    ctrl  = '0;
    tail  = head;
    drop  = 1'b0;
    fire  = 1'b0;
    match = (head.phase != dtt_pkg::PHASE_EMPTY) && (head.id == id_q);
    tdec  = head.tim - 16'd1;

    case (state_q)
      dtt_pkg::S_IDLE: begin
        if (start) begin
          op_d  = opcode_i;
          id_d  = action_id_i;
          arg_d = action_arg_i;
          ph_d  = phase_i;
          amt_d = amount_i;
          rem_d = used_q;
          len_d = used_q;
          fin_d = used_q;
          kept_d = '0;
          hit_d  = 1'b0;
          rstat_d = dtt_pkg::ST_OK;
          rslot_d = '0;
          case (opcode_i)
            dtt_pkg::OP_INSERT: begin
              if (used_q < CW'(dtt_pkg::TABLE_DEPTH)) begin
                ctrl.wr_en   = 1'b1;
                ctrl.wr_idx  = used_q;
                ctrl.wr_data = '{id: action_id_i, arg: action_arg_i,
                                 phase: phase_i, tim: amount_i};
                used_d  = used_q + CW'(1);
                rslot_d = used_q[IW-1:0];
              end else begin
                rstat_d = dtt_pkg::ST_FULL;
              end
              state_d = dtt_pkg::S_DONE;
            end
            dtt_pkg::OP_LENGTHEN, dtt_pkg::OP_EXTING, dtt_pkg::OP_FIND,
            dtt_pkg::OP_DAEMONS: state_d = dtt_pkg::S_WALK;
            dtt_pkg::OP_TICK:    state_d = dtt_pkg::S_PRE;
            default:             state_d = dtt_pkg::S_DONE;
          endcase
        end
      end

      // Rotate once without change to count the fuses that will burn out.
      dtt_pkg::S_PRE: begin
        if (rem_q == '0) begin
          rem_d   = used_q;
          state_d = dtt_pkg::S_WALK;
        end else begin
          ctrl.shift_en = 1'b1;
          ctrl.lim      = used_q - CW'(1);
          ctrl.wr_en    = 1'b1;
          ctrl.wr_idx   = used_q - CW'(1);
          ctrl.wr_data  = head;
          if (head.phase == dtt_pkg::PHASE_AFTER && head.tim == dtt_pkg::TIME_ONE) begin
            fin_d = fin_q - CW'(1);
          end
          rem_d = rem_q - CW'(1);
        end
      end

      dtt_pkg::S_WALK: begin
        if (rem_q == '0) begin
          used_d = len_q;
          if (op_q == dtt_pkg::OP_LENGTHEN || op_q == dtt_pkg::OP_EXTING ||
              op_q == dtt_pkg::OP_FIND) begin
            rstat_d = hit_q ? dtt_pkg::ST_OK : dtt_pkg::ST_NOTFOUND;
          end
          state_d = dtt_pkg::S_DONE;
        end else begin
          case (op_q)
            dtt_pkg::OP_LENGTHEN: begin
              if (match) begin
                tail.tim = head.tim + amt_q;
                hit_d    = 1'b1;
              end
            end
            dtt_pkg::OP_EXTING: begin
              if (match) begin
                drop  = 1'b1;
                hit_d = 1'b1;
              end
            end
            dtt_pkg::OP_FIND: begin
              if (match && !hit_q) begin
                hit_d   = 1'b1;
                rslot_d = kept_q[IW-1:0];
              end
            end
            dtt_pkg::OP_DAEMONS: begin
              fire = (head.phase == ph_q) && (head.tim == dtt_pkg::TIME_DAEMON);
            end
            dtt_pkg::OP_TICK: begin
              if (head.phase == dtt_pkg::PHASE_AFTER && !head.tim[15]) begin
                tail.tim = tdec;
                if (tdec == '0) begin
                  fire = 1'b1;
                  drop = 1'b1;
                end
              end
            end
            default: ;
          endcase
          // Pop the head, push it back at the top of the live region (empty if dropped).
          ctrl.shift_en = 1'b1;
          ctrl.lim      = len_q - CW'(1);
          ctrl.wr_en    = 1'b1;
          ctrl.wr_idx   = len_q - CW'(1);
          ctrl.wr_data  = drop ? '0 : tail;
          if (drop) begin
            len_d = len_q - CW'(1);
          end else begin
            kept_d = kept_q + CW'(1);
          end
          rem_d = rem_q - CW'(1);
          if (fire) begin
            ov_d    = 1'b1;
            of_d    = 1'b1;
            ol_d    = 1'b0;
            oid_d   = head.id;
            oarg_d  = head.arg;
            ost_d   = dtt_pkg::ST_OK;
            oslot_d = kept_q[IW-1:0];
            ocnt_d  = (op_q == dtt_pkg::OP_TICK) ? fin_q : used_q;
          end
        end
      end

      dtt_pkg::S_DONE: begin
        ov_d    = 1'b1;
        of_d    = 1'b0;
        ol_d    = 1'b1;
        oid_d   = (op_q <= dtt_pkg::OP_FIND) ? id_q : 8'd0;
        oarg_d  = '0;
        ost_d   = rstat_q;
        oslot_d = rslot_q;
        ocnt_d  = used_q;
        state_d = dtt_pkg::S_IDLE;
      end

      default: state_d = dtt_pkg::S_IDLE;
    endcase
  end

  assign busy          = (state_q != dtt_pkg::S_IDLE);
  assign valid_o       = ov_q;
  assign fired_o       = of_q;
  assign fired_id_o    = oid_q;
  assign fired_arg_o   = oarg_q;
  assign status_o      = ost_q;
  assign slot_o        = oslot_q;
  assign entry_count_o = ocnt_q;
  assign last_o        = ol_q;

endmodule
`default_nettype wire

>>> rtl/dtt_checker.sv
// ----------------------------------------------------------------------------
// dtt_checker: port-level checks of the timer table
// Watches command and result ports; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module dtt_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        valid_o,
  input wire logic        fired_o,
  input wire logic [1:0]  status_o,
  input wire logic [5:0]  entry_count_o,
  input wire logic        last_o
);

  // accepted transaction must raise busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("busy not raised");

  // closing result leaves the unit free
  a_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && last_o |-> !busy) else $error("busy after closing result");

  a_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && fired_o |-> !last_o) else $error("fired result marked last");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> entry_count_o <= 6'(dtt_pkg::TABLE_DEPTH))
    else $error("entry count beyond depth");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o == dtt_pkg::ST_FULL |->
      entry_count_o == 6'(dtt_pkg::TABLE_DEPTH))
    else $error("full status with free slots");

endmodule

bind delayed_action_timer_table_unit dtt_checker u_dtt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .valid_o       (valid_o),
  .fired_o       (fired_o),
  .status_o      (status_o),
  .entry_count_o (entry_count_o),
  .last_o        (last_o)
);
`default_nettype wire
